// ----- hw/rtl/msp_pkg.sv -----
// msp_pkg: shared constants, types and codes for the minimum spacing point table.
// No dependencies; imported by every module under hw/rtl except msp_point_ram.
package msp_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 16;
  localparam int OFFS_W     = 10;
  localparam int FRAC_BITS  = 4;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ENTRY_W    = 2 * COORD_W + 1;  // {lock, x, y}
  localparam int WRAP_W     = COORD_W + 5;      // headroom for offset, field size and doubling
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;      // a square of a DIFF_W difference fits here
  localparam int SUM_W      = SQ_W + 1;
  localparam int MS2_W      = 2 * CFG_W;

  localparam logic [CFG_W-1:0] RST_MIN_SPACING  = CFG_W'(576);
  localparam logic [CFG_W-1:0] RST_FIELD_WIDTH  = CFG_W'(512);
  localparam logic [CFG_W-1:0] RST_FIELD_HEIGHT = CFG_W'(512);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_TOO_CLOSE = 3'd1,
    STS_FULL      = 3'd2,
    STS_LOCKED    = 3'd3,
    STS_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MV_RD,
    S_MV_LK,
    S_MV_WRAP,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_spacing;
    logic [CFG_W-1:0] field_width;
    logic [CFG_W-1:0] field_height;
  } cfg_t;

  // One stored entry on its way from the memory into the distance pipeline.
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } scan_item_t;

endpackage

// ----- hw/rtl/msp_point_ram.sv -----
// msp_point_ram: generic single-port-write, single-port-read RAM, registered read.
// No package dependency.
module msp_point_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/msp_dist_unit.sv -----
// msp_dist_unit: three-stage squared distance check of one stored entry per cycle.
// Depends on msp_pkg.
module msp_dist_unit import msp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  scan_item_t                item,
  input  logic signed [COORD_W-1:0] cand_x,
  input  logic signed [COORD_W-1:0] cand_y,
  input  logic                      skip_en,
  input  logic [IDX_W-1:0]          skip_idx,
  input  logic [CFG_W-1:0]          min_spacing,
  output logic                      hit,
  output logic                      busy
);

  logic                     v1, v2, v3;
  logic                     skip1, skip2;
  logic signed [DIFF_W-1:0] dx1, dy1;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]          sq_x, sq_y;
  logic [MS2_W-1:0]         ms2;
  logic                     close3;
  logic [SUM_W-1:0]         dist2;

  assign prod_x = dx1 * dx1;
  assign prod_y = dy1 * dy1;
  assign dist2  = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: differences
    dx1   <= signed'({item.x[COORD_W-1], item.x}) - signed'({cand_x[COORD_W-1], cand_x});
    dy1   <= signed'({item.y[COORD_W-1], item.y}) - signed'({cand_y[COORD_W-1], cand_y});
    skip1 <= skip_en && (item.idx == skip_idx);
    // stage 2: squares
    sq_x  <= prod_x[SQ_W-1:0];
    sq_y  <= prod_y[SQ_W-1:0];
    skip2 <= skip1;
    ms2   <= MS2_W'(min_spacing) * MS2_W'(min_spacing);
    // stage 3: sum and compare
    close3 <= (dist2 <= {{(SUM_W-MS2_W){1'b0}}, ms2}) && !skip2;
  end

  assign hit  = v3 && close3;
  assign busy = v1 || v2 || v3;

endmodule

// ----- hw/rtl/msp_ctrl.sv -----
// msp_ctrl: request sequencer, wraparound arithmetic, point count and result register.
// Depends on msp_pkg; drives msp_point_ram and msp_dist_unit.
module msp_ctrl import msp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      locked,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic signed [OFFS_W-1:0]  offset_x,
  input  logic signed [OFFS_W-1:0]  offset_y,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [IDX_W-1:0]          entry_used,
  output logic [CNT_W-1:0]          point_count,
  // point memory
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  input  logic [ENTRY_W-1:0]        rd_data,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [ENTRY_W-1:0]        wr_data,
  // distance pipeline
  output scan_item_t                item,
  output logic signed [COORD_W-1:0] cand_x,
  output logic signed [COORD_W-1:0] cand_y,
  output logic                      skip_en,
  output logic [IDX_W-1:0]          skip_idx,
  input  logic                      hit,
  input  logic                      busy
);

  // First wrap step: add the field size when below minus half of it.
  function automatic logic signed [WRAP_W-1:0] wrap_low(
    input logic signed [WRAP_W-1:0] v,
    input logic [CFG_W-1:0]         size
  );
    logic signed [WRAP_W-1:0] w;
    w = signed'({{(WRAP_W-CFG_W-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}});
    if ((v <<< 1) < -w) begin
      return v + w;
    end
    return v;
  endfunction

  // Second wrap step, then saturate to the coordinate range.
  function automatic logic signed [COORD_W-1:0] wrap_high(
    input logic signed [WRAP_W-1:0] v,
    input logic [CFG_W-1:0]         size
  );
    logic signed [WRAP_W-1:0] w;
    logic signed [WRAP_W-1:0] r;
    w = signed'({{(WRAP_W-CFG_W-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}});
    r = v;
    if ((v <<< 1) > w) begin
      r = v - w;
    end
    if (r[WRAP_W-1:COORD_W-1] == {(WRAP_W-COORD_W+1){1'b0}} ||
        r[WRAP_W-1:COORD_W-1] == {(WRAP_W-COORD_W+1){1'b1}}) begin
      return r[COORD_W-1:0];
    end
    if (r[WRAP_W-1]) begin
      return signed'({1'b1, {(COORD_W-1){1'b0}}});
    end
    return signed'({1'b0, {(COORD_W-1){1'b1}}});
  endfunction

  fsm_t                      state, state_next;
  kind_t                     req_kind;
  logic                      req_lock;
  logic [IDX_W-1:0]          req_idx;
  logic signed [OFFS_W-1:0]  off_x, off_y;
  logic signed [WRAP_W-1:0]  w1_x, w1_y;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          scan_n;
  logic                      rd_vld;
  logic [IDX_W-1:0]          rd_idx;
  logic                      hit_acc;
  status_t                   res_status;
  logic [IDX_W-1:0]          res_used;
  logic                      scan_rd;
  logic                      load_out;
  logic                      accept;
  logic signed [COORD_W-1:0] mem_x, mem_y;

  assign mem_x  = rd_data[2*COORD_W-1:COORD_W];
  assign mem_y  = rd_data[COORD_W-1:0];
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_n[IDX_W-1:0];
    scan_rd    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = req_idx;
    wr_data    = {1'b0, cand_x, cand_y};
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kind_t'(kind))
            KIND_PUSH: begin
              state_next = (cnt == CNT_W'(CAPACITY)) ? S_DONE : S_SCAN;
            end
            KIND_MOVE: begin
              state_next = ({1'b0, entry_index} >= cnt) ? S_DONE : S_MV_RD;
            end
            KIND_CLEAR, KIND_NONE: begin
              state_next = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MV_RD: begin
        rd_en      = 1'b1;
        rd_addr    = req_idx;
        state_next = S_MV_LK;
      end
      S_MV_LK: begin
        state_next = rd_data[ENTRY_W-1] ? S_DONE : S_MV_WRAP;
      end
      S_MV_WRAP: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_n == cnt) begin
          state_next = S_DRAIN;
        end else begin
          rd_en   = 1'b1;
          scan_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld && !busy) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!hit_acc) begin
          wr_en = 1'b1;
          if (req_kind == KIND_PUSH) begin
            wr_addr = cnt[IDX_W-1:0];
            wr_data = {req_lock, cand_x, cand_y};
          end
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      scan_n    <= '0;
      rd_vld    <= 1'b0;
      hit_acc   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_rd;
      if (accept) begin
        scan_n  <= '0;
        hit_acc <= 1'b0;
        if (kind_t'(kind) == KIND_CLEAR) begin
          cnt <= '0;
        end
      end else begin
        if (scan_rd) begin
          scan_n <= scan_n + CNT_W'(1);
        end
        if (hit) begin
          hit_acc <= 1'b1;
        end
      end
      if (state == S_COMMIT && !hit_acc && req_kind == KIND_PUSH) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    rd_idx <= scan_n[IDX_W-1:0];
    if (accept) begin
      req_kind   <= kind_t'(kind);
      req_lock   <= locked;
      req_idx    <= entry_index;
      off_x      <= offset_x;
      off_y      <= offset_y;
      cand_x     <= point_x;
      cand_y     <= point_y;
      unique case (kind_t'(kind))
        KIND_PUSH: begin
          if (cnt == CNT_W'(CAPACITY)) begin
            res_status <= STS_FULL;
            res_used   <= '0;
          end else begin
            res_status <= STS_OK;
            res_used   <= cnt[IDX_W-1:0];
          end
        end
        KIND_MOVE: begin
          res_used <= entry_index;
          if ({1'b0, entry_index} >= cnt) begin
            res_status <= STS_BAD_INDEX;
          end else begin
            res_status <= STS_OK;
          end
        end
        KIND_CLEAR, KIND_NONE: begin
          res_status <= STS_OK;
          res_used   <= '0;
        end
        default: begin
          res_status <= STS_OK;
          res_used   <= '0;
        end
      endcase
    end
    if (state == S_MV_LK) begin
      if (rd_data[ENTRY_W-1]) begin
        res_status <= STS_LOCKED;
      end
      w1_x <= wrap_low(signed'({{(WRAP_W-COORD_W){mem_x[COORD_W-1]}}, mem_x})
                     + signed'({{(WRAP_W-OFFS_W){off_x[OFFS_W-1]}}, off_x}),
                       cfg.field_width);
      w1_y <= wrap_low(signed'({{(WRAP_W-COORD_W){mem_y[COORD_W-1]}}, mem_y})
                     + signed'({{(WRAP_W-OFFS_W){off_y[OFFS_W-1]}}, off_y}),
                       cfg.field_height);
    end
    if (state == S_MV_WRAP) begin
      cand_x <= wrap_high(w1_x, cfg.field_width);
      cand_y <= wrap_high(w1_y, cfg.field_height);
    end
    if (state == S_COMMIT && hit_acc) begin
      res_status <= STS_TOO_CLOSE;
    end
    if (load_out) begin
      status      <= res_status;
      entry_used  <= res_used;
      point_count <= cnt;
    end
  end

  assign item.valid = rd_vld;
  assign item.idx   = rd_idx;
  assign item.x     = mem_x;
  assign item.y     = mem_y;
  assign skip_en    = (req_kind == KIND_MOVE);
  assign skip_idx   = req_idx;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("point count above capacity");

  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_COMMIT) && !busy && !rd_vld)
    else $error("memory write while the scan is in flight");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !busy && !rd_vld)
    else $error("request taken with the distance pipeline busy");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !hit_acc && req_kind == KIND_PUSH)
      |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("accepted push did not bump the count");
`endif

endmodule

// ----- hw/rtl/min_spacing_point_table_unit.sv -----
// min_spacing_point_table_unit: top level, configuration registers and submodule wiring.
// Depends on msp_pkg, msp_point_ram, msp_dist_unit and msp_ctrl.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  config   | cfg_we                | cfg_index, cfg_wdata
//  request  | in_valid / in_ready   | kind, point_x, point_y, locked, entry_index,
//           |                       | offset_x, offset_y
//  result   | out_valid / out_ready | status, entry_used, point_count
//
// A push or a move scans the stored points, one point memory read per cycle into a
// three-stage squared distance pipeline, waits for the pipeline to drain and writes
// the entry unless a stored point is too close; a move first reads the entry and
// checks its lock bit. Clear, a push to a full table, a move to a bad index and a
// locked move skip the scan.
// Reset (rst, synchronous): count to zero, spacing and field registers to their
// defaults; the point memory is not cleared, entries at or above count are never read.
// Stalls: one request at a time; a finished result sits in the output register so
// the next request is taken while out_ready is low, and only its own result waits.
module min_spacing_point_table_unit import msp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  // request
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      locked,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic signed [OFFS_W-1:0]  offset_x,
  input  logic signed [OFFS_W-1:0]  offset_y,
  // result
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [IDX_W-1:0]          entry_used,
  output logic [CNT_W-1:0]          point_count
);

  cfg_t                      cfg;
  logic                      rd_en, wr_en;
  logic [IDX_W-1:0]          rd_addr, wr_addr;
  logic [ENTRY_W-1:0]        rd_data, wr_data;
  scan_item_t                item;
  logic signed [COORD_W-1:0] cand_x, cand_y;
  logic                      skip_en;
  logic [IDX_W-1:0]          skip_idx;
  logic                      hit, busy;

  // Config registers; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_spacing  <= RST_MIN_SPACING;
      cfg.field_width  <= RST_FIELD_WIDTH;
      cfg.field_height <= RST_FIELD_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SPACING:  cfg.min_spacing  <= cfg_wdata;
        REG_FIELD_WIDTH:  cfg.field_width  <= cfg_wdata;
        REG_FIELD_HEIGHT: cfg.field_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // {lock, x, y} per entry
  msp_point_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  msp_dist_unit u_dist (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .skip_en     (skip_en),
    .skip_idx    (skip_idx),
    .min_spacing (cfg.min_spacing),
    .hit         (hit),
    .busy        (busy)
  );

  msp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .point_x     (point_x),
    .point_y     (point_y),
    .locked      (locked),
    .entry_index (entry_index),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_used  (entry_used),
    .point_count (point_count),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .item        (item),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .skip_en     (skip_en),
    .skip_idx    (skip_idx),
    .hit         (hit),
    .busy        (busy)
  );

endmodule
